/* rtl/max_pool_2d_with_argmax_defines.svh */
// Assertion macros shared by the max pooling block.
`ifndef MAX_POOL_2D_WITH_ARGMAX_DEFINES_SVH
`define MAX_POOL_2D_WITH_ARGMAX_DEFINES_SVH
// Condition must never hold at a clock edge outside reset.
`define MP2D_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
// Antecedent implies consequent in the following cycle.
`define MP2D_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`endif

/* rtl/mp2d_pkg.sv */
// Package for the max pooling block: sizes, register indexes and shared types.
package mp2d_pkg;
	localparam int POOL_MAX = 8;
	localparam int MAX_W    = 1024;
	localparam int DATA_W   = 16;
	localparam int Q_DEPTH  = 4;

	typedef enum logic [2:0] {
		CFG_POOL_H   = 3'd0,
		CFG_POOL_W   = 3'd1,
		CFG_STRIDE_H = 3'd2,
		CFG_STRIDE_W = 3'd3,
		CFG_PLANE_H  = 3'd4,
		CFG_PLANE_W  = 3'd5
	} cfg_idx_t;

	// Horizontal maximum of one row segment and its column offset.
	typedef struct packed {
		logic [DATA_W-1:0] val;
		logic [2:0]        off;
	} line_t;

	// One horizontal window handed from front to back.
	typedef struct packed {
		logic [POOL_MAX-1:0][DATA_W-1:0] pix;  // pix[j] is column left+j
		logic [2:0] pwm1;                     // window width minus one
		logic [2:0] phm1;                     // window height minus one
		logic [2:0] bank;                     // row modulo POOL_MAX
		logic [9:0] left;
		logic [9:0] top;
		logic [9:0] orow;
		logic [9:0] ocol;
		logic       emit;
		logic       last;
	} q_item_t;
endpackage

/* rtl/mp2d_front.sv */
// Front end: configuration, plane position tracking and window classification.
module mp2d_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_index,
	input  logic [10:0]           cfg_data,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  logic [15:0]           pixel_value,
	output logic                  push,
	output mp2d_pkg::q_item_t     push_item
);
	import mp2d_pkg::*;

	logic [3:0]  ph_q, pw_q, sh_q, sw_q;
	logic [10:0] hh_q, ww_q;
	logic [3:0]  ph_e, pw_e, sh_e, sw_e;
	logic [10:0] hh_e, ww_e;
	logic [9:0]  r_q, c_q;
	logic [10:0] nxt_left_q, nxt_top_q;
	logic [9:0]  orow_q, ocol_q;
	logic [POOL_MAX-1:0][DATA_W-1:0] recent_q;
	logic [POOL_MAX-1:0][DATA_W-1:0] win;
	logic [10:0] cp1, rp1, left_w, top_w;
	logic        hwin, vwin, acc, row_end, plane_end;
	logic [2:0]  pwm1;

	// Clamp register values into their working ranges.
	always_comb begin
		ph_e = (ph_q == 4'd0) ? 4'd1 : ((ph_q > 4'd8) ? 4'd8 : ph_q);
		pw_e = (pw_q == 4'd0) ? 4'd1 : ((pw_q > 4'd8) ? 4'd8 : pw_q);
		sh_e = (sh_q == 4'd0) ? 4'd1 : sh_q;
		sw_e = (sw_q == 4'd0) ? 4'd1 : sw_q;
		hh_e = (hh_q == 11'd0) ? 11'd1 : ((hh_q > 11'd1024) ? 11'd1024 : hh_q);
		ww_e = (ww_q == 11'd0) ? 11'd1 : ((ww_q > 11'd1024) ? 11'd1024 : ww_q);
	end

	// Classify the incoming pixel.
	always_comb begin
		acc       = in_valid && !in_stall;
		cp1       = {1'b0, c_q} + 11'd1;
		rp1       = {1'b0, r_q} + 11'd1;
		left_w    = cp1 - {7'd0, pw_e};
		top_w     = rp1 - {7'd0, ph_e};
		hwin      = (cp1 >= {7'd0, pw_e}) && (left_w == nxt_left_q);
		vwin      = (rp1 >= {7'd0, ph_e}) && (top_w == nxt_top_q);
		row_end   = cp1 >= ww_e;
		plane_end = rp1 >= hh_e;
		pwm1      = 3'(pw_e - 4'd1);
		win[0]    = pixel_value;
		for (int k = 1; k < POOL_MAX; k++) win[k] = recent_q[k-1];
	end

	// Build the queue item, leftmost column first.
	always_comb begin
		for (int j = 0; j < POOL_MAX; j++) push_item.pix[j] = win[pwm1 - 3'(j)];
		push_item.pwm1 = pwm1;
		push_item.phm1 = 3'(ph_e - 4'd1);
		push_item.bank = r_q[2:0];
		push_item.left = left_w[9:0];
		push_item.top  = top_w[9:0];
		push_item.orow = orow_q;
		push_item.ocol = ocol_q;
		push_item.emit = vwin;
		push_item.last = ({1'b0, r_q} + {7'd0, sh_e} >= hh_e) &&
		                 ({1'b0, c_q} + {7'd0, sw_e} >= ww_e);
		push = acc && hwin;
	end

	// Load configuration and restart the plane on a write; advance positions and window counters per accepted pixel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= 4'd2; pw_q <= 4'd2; sh_q <= 4'd2; sw_q <= 4'd2;
			hh_q <= 11'd32; ww_q <= 11'd32;
			r_q <= '0; c_q <= '0; nxt_left_q <= '0; nxt_top_q <= '0;
			orow_q <= '0; ocol_q <= '0; recent_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_POOL_H:   ph_q <= cfg_data[3:0];
				CFG_POOL_W:   pw_q <= cfg_data[3:0];
				CFG_STRIDE_H: sh_q <= cfg_data[3:0];
				CFG_STRIDE_W: sw_q <= cfg_data[3:0];
				CFG_PLANE_H:  hh_q <= cfg_data;
				CFG_PLANE_W:  ww_q <= cfg_data;
				default: ;
			endcase
			r_q <= '0; c_q <= '0; nxt_left_q <= '0; nxt_top_q <= '0;
			orow_q <= '0; ocol_q <= '0; recent_q <= '0;
		end else if (acc) begin
			recent_q <= win;
			if (row_end) begin
				c_q        <= '0;
				nxt_left_q <= '0;
				ocol_q     <= '0;
				if (plane_end) begin
					r_q       <= '0;
					nxt_top_q <= '0;
					orow_q    <= '0;
				end else begin
					r_q <= r_q + 10'd1;
					if (vwin) begin
						nxt_top_q <= nxt_top_q + {7'd0, sh_e};
						orow_q    <= orow_q + 10'd1;
					end
				end
			end else begin
				c_q <= c_q + 10'd1;
				if (hwin) begin
					nxt_left_q <= nxt_left_q + {7'd0, sw_e};
					ocol_q     <= ocol_q + 10'd1;
				end
			end
		end
	end
endmodule

/* rtl/mp2d_queue.sv */
// Short queue of window items between front and back.
module mp2d_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  mp2d_pkg::q_item_t push_item,
	input  logic              pop,
	output mp2d_pkg::q_item_t head,
	output logic              empty,
	output logic              full
);
	import mp2d_pkg::*;
	`include "max_pool_2d_with_argmax_defines.svh"

	q_item_t    mem_q [Q_DEPTH];
	logic [1:0] wr_q, rd_q;
	logic [2:0] count_q;

	assign empty = count_q == 3'd0;
	assign full  = count_q == 3'(Q_DEPTH);
	assign head  = mem_q[rd_q];

	// Store pushed items.
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_item;
	end

	// Advance pointers and count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0; rd_q <= '0; count_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 2'd1;
			if (pop)  rd_q <= rd_q + 2'd1;
			if (push && !pop) count_q <= count_q + 3'd1;
			else if (pop && !push) count_q <= count_q - 3'd1;
		end
	end

	`MP2D_NEVER(a_q_no_overflow, push && full, "queue push while full")
	`MP2D_NEXT(a_q_count_up, push && !pop, count_q == $past(count_q) + 3'd1, "queue count slip")
endmodule

/* rtl/mp2d_back.sv */
// Back end: horizontal max, line store banks, vertical reduction, output register.
module mp2d_back (
	input  logic              clk,
	input  logic              arst_n,
	input  mp2d_pkg::q_item_t head,
	input  logic              empty,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [15:0]       max_value,
	output logic [9:0]        source_row,
	output logic [9:0]        source_col,
	output logic [9:0]        out_row,
	output logic [9:0]        out_col,
	output logic              last_in_plane
);
	import mp2d_pkg::*;
	`include "max_pool_2d_with_argmax_defines.svh"

	logic    advance;
	logic    s1_v_q, s2_v_q, out_v_q, fwd_q;
	q_item_t s1_q, s2_q;
	line_t   h_s1, s2_h, fwd_ent_q, best;
	logic [2:0] fwd_bank_q, bk, bi;
	line_t   rd_q [POOL_MAX];
	line_t   ent  [POOL_MAX];
	logic [9:0] brow;

	assign advance   = !out_v_q || !out_stall;
	assign pop       = advance && !empty;
	assign out_valid = out_v_q;

	// Horizontal maximum over the window, leftmost wins ties.
	always_comb begin
		h_s1.val = s1_q.pix[0];
		h_s1.off = 3'd0;
		for (int j = 1; j < POOL_MAX; j++) begin
			if (3'(j) <= s1_q.pwm1 && $signed(s1_q.pix[j]) > $signed(h_s1.val)) begin
				h_s1.val = s1_q.pix[j];
				h_s1.off = 3'(j);
			end
		end
	end

	// Line store banks, one per row modulo the window height limit.
	for (genvar b = 0; b < POOL_MAX; b++) begin : g_bank
		line_t mem [MAX_W];
		always_ff @(posedge clk) begin
			if (advance) begin
				if (s2_v_q && s2_q.bank == 3'(b)) mem[s2_q.left] <= s2_h;
				rd_q[b] <= mem[s1_q.left];
			end
		end
	end

	// Select bank data: own row from the fresh max, forward the write just done.
	always_comb begin
		for (int b = 0; b < POOL_MAX; b++) begin
			if (3'(b) == s2_q.bank) ent[b] = s2_h;
			else if (fwd_q && 3'(b) == fwd_bank_q) ent[b] = fwd_ent_q;
			else ent[b] = rd_q[b];
		end
	end

	// Vertical reduction, larger value then smaller column then smaller row.
	always_comb begin
		bk   = s2_q.top[2:0];
		bi   = bk;
		best = ent[bk];
		brow = s2_q.top;
		for (int d = 1; d < POOL_MAX; d++) begin
			bi = bk + 3'(d);
			if (3'(d) <= s2_q.phm1 &&
			    ($signed(ent[bi].val) > $signed(best.val) ||
			     (ent[bi].val == best.val && ent[bi].off < best.off))) begin
				best = ent[bi];
				brow = s2_q.top + 10'(d);
			end
		end
	end

	// Advance stage valids.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0; s2_v_q <= 1'b0; out_v_q <= 1'b0; fwd_q <= 1'b0;
		end else if (advance) begin
			s1_v_q  <= !empty;
			s2_v_q  <= s1_v_q;
			out_v_q <= s2_v_q && s2_q.emit;
			fwd_q   <= s2_v_q && (s2_q.left == s1_q.left);
		end
	end

	// Move payload through the stages.
	always_ff @(posedge clk) begin
		if (advance) begin
			if (!empty) s1_q <= head;
			s2_q          <= s1_q;
			s2_h          <= h_s1;
			fwd_bank_q    <= s2_q.bank;
			fwd_ent_q     <= s2_h;
			max_value     <= best.val;
			source_row    <= brow;
			source_col    <= s2_q.left + {7'd0, best.off};
			out_row       <= s2_q.orow;
			out_col       <= s2_q.ocol;
			last_in_plane <= s2_q.last;
		end
	end

	`MP2D_NEXT(a_pop_loads_s1, pop, s1_v_q, "popped item did not reach stage one")
endmodule

/* rtl/max_pool_2d_with_argmax.sv */
// Windows pass the queue, stage one, stage two and output register; throughput is one pixel
// per cycle unless stalled; the line store banks then take one write and one read per cycle.
// A 4-entry queue lets the front keep accepting while the output is stalled, until it fills.
// Reset: asynchronous, active low; registers return to 2x2 pool, stride 2, 32x32 plane.
// The line store has no reset; each entry is written before it is read within a plane.
module max_pool_2d_with_argmax (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [10:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] pixel_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] max_value,
	output logic [9:0]  source_row,
	output logic [9:0]  source_col,
	output logic [9:0]  out_row,
	output logic [9:0]  out_col,
	output logic        last_in_plane
);
	import mp2d_pkg::*;

	logic    push, pop, empty, full;
	q_item_t push_item, head;

	assign in_stall = full;

	mp2d_front u_front (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.in_valid, .in_stall, .pixel_value, .push, .push_item
	);

	mp2d_queue u_queue (
		.clk, .arst_n, .push, .push_item, .pop, .head, .empty, .full
	);

	mp2d_back u_back (
		.clk, .arst_n, .head, .empty, .pop, .out_valid, .out_stall,
		.max_value, .source_row, .source_col, .out_row, .out_col, .last_in_plane
	);
endmodule
